/* rtl/dbdf_pkg.sv */
`timescale 1ns / 1ps

package dbdf_pkg;

    // Record layout
    localparam int BOX_FIELDS = 5;
    localparam int MAX_RECORD = 128;
    localparam int MIN_RECORD = 6;

    // Field widths
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 7;
    localparam int LABEL_W  = 7;
    localparam int LEN_W    = 8;
    localparam int THRESH_W = 17;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 17;
    localparam int PROD_W   = 2 * VALUE_W;
    localparam int FRAC_W   = 16;
    localparam int CONF_W   = PROD_W - FRAC_W;
    localparam int OUT_DATA_W = 168;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RECORD_LENGTH        = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CONFIDENCE_THRESHOLD = 8'd1;

    // Register reset values
    localparam logic [LEN_W-1:0]    RECORD_LENGTH_RST = 8'd85;
    localparam logic [THRESH_W-1:0] THRESHOLD_RST     = 17'd22938;

    localparam logic [LEN_W-1:0] LEN_MIN = LEN_W'(MIN_RECORD);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_RECORD);
    localparam logic [POS_W-1:0] POS_FIRST_SCORE = POS_W'(BOX_FIELDS);

    localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

    // Record end snapshot, ahead of the multiply
    typedef struct packed {
        logic                        last;
        logic                        rec_end;
        logic signed [VALUE_W-1:0]   best;
        logic [LABEL_W-1:0]          label;
        logic signed [VALUE_W-1:0]   obj;
        logic signed [VALUE_W-1:0]   cx;
        logic signed [VALUE_W-1:0]   cy;
        logic signed [VALUE_W-1:0]   sw;
        logic signed [VALUE_W-1:0]   sh;
    } s1_t;

    // Product stage
    typedef struct packed {
        logic                        last;
        logic                        rec_end;
        logic signed [PROD_W-1:0]    prod;
        logic [LABEL_W-1:0]          label;
        logic signed [VALUE_W-1:0]   cx;
        logic signed [VALUE_W-1:0]   cy;
        logic signed [VALUE_W-1:0]   sw;
        logic signed [VALUE_W-1:0]   sh;
    } s2_t;

endpackage

/* rtl/detection_box_decode_filter_core.sv */
`timescale 1ns / 1ps

// Detection record decoder with confidence filter.
// A result passes through stage 1, stage 2 and the output register before m_tvalid.
// Throughput: one input transaction per cycle unless m_tready stalls; the argmax compare
// and the 32x32 multiply each sit in their own pipeline stage, so nothing iterates.
// Reset (rst_n low, asynchronous): pipeline empty, record position 0, registers to defaults.
module detection_box_decode_filter_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    // Input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [dbdf_pkg::VALUE_W-1:0]        s_tdata,   // [31:0] value
    input  logic                                s_tlast,   // last_in_frame
    // Result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [6:0] label, [38:7] confidence, [70:39] left, [102:71] top,
    // [134:103] box_width, [166:135] box_height, [167] zero
    output logic [dbdf_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                                m_tuser,   // box_valid
    output logic                                m_tlast,   // frame_done
    // Configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dbdf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dbdf_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int VW = dbdf_pkg::VALUE_W;

    // Configuration registers
    logic [dbdf_pkg::LEN_W-1:0]    record_length_reg;
    logic [dbdf_pkg::THRESH_W-1:0] threshold_reg;

    // Record state
    logic [dbdf_pkg::POS_W-1:0]    field_position_reg;
    logic signed [VW-1:0]          centre_x_reg;
    logic signed [VW-1:0]          centre_y_reg;
    logic signed [VW-1:0]          span_w_reg;
    logic signed [VW-1:0]          span_h_reg;
    logic signed [VW-1:0]          objectness_reg;
    logic signed [VW-1:0]          best_score_reg;
    logic [dbdf_pkg::LABEL_W-1:0]  best_class_reg;

    // Pipeline
    logic              s1_valid_reg;
    dbdf_pkg::s1_t     s1_reg;
    dbdf_pkg::s1_t     s1_next;
    logic              s2_valid_reg;
    dbdf_pkg::s2_t     s2_reg;
    logic              out_valid_reg;
    logic [dbdf_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic [dbdf_pkg::OUT_DATA_W-1:0] out_data_next;
    logic              out_user_reg;
    logic              out_last_reg;

    logic out_can_load;
    logic s2_can_load;
    logic s1_can_load;
    logic s_accept;

    // Input stage signals
    logic [dbdf_pkg::LEN_W-1:0]    len_eff;
    logic [dbdf_pkg::LEN_W-1:0]    pos_plus1;
    logic                          rec_end;
    logic                          is_score;
    logic                          better;
    logic signed [VW-1:0]          value_in;
    logic signed [VW-1:0]          best_now;
    logic [dbdf_pkg::LABEL_W-1:0]  class_now;

    // Output stage signals
    logic signed [dbdf_pkg::CONF_W-1:0] conf_full;
    logic                          keep;
    logic                          emit;
    logic signed [VW-1:0]          conf_sat;
    logic signed [VW-1:0]          half_w;
    logic signed [VW-1:0]          half_h;
    logic signed [VW:0]            left_full;
    logic signed [VW:0]            top_full;
    logic signed [VW-1:0]          left_sat;
    logic signed [VW-1:0]          top_sat;

    // Handshakes: each stage loads when it is empty or drains this cycle
    assign out_can_load = !out_valid_reg || m_tready;
    assign s2_can_load  = !s2_valid_reg || out_can_load;
    assign s1_can_load  = !s1_valid_reg || s2_can_load;
    assign s_tready     = s1_can_load;
    assign s_accept     = s_tvalid && s_tready;
    assign cfg_ready    = 1'b1;

    // Configuration writes; unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            record_length_reg <= dbdf_pkg::RECORD_LENGTH_RST;
            threshold_reg     <= dbdf_pkg::THRESHOLD_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                dbdf_pkg::REG_RECORD_LENGTH:
                    record_length_reg <= cfg_data[dbdf_pkg::LEN_W-1:0];
                dbdf_pkg::REG_CONFIDENCE_THRESHOLD:
                    threshold_reg <= cfg_data[dbdf_pkg::THRESH_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // Record position, length clamp and running argmax
    always_comb
    begin
        if (record_length_reg < dbdf_pkg::LEN_MIN)
            len_eff = dbdf_pkg::LEN_MIN;
        else if (record_length_reg > dbdf_pkg::LEN_MAX)
            len_eff = dbdf_pkg::LEN_MAX;
        else
            len_eff = record_length_reg;

        value_in  = $signed(s_tdata);
        pos_plus1 = {1'b0, field_position_reg} + dbdf_pkg::LEN_W'(1);
        rec_end   = pos_plus1 >= len_eff;
        is_score  = field_position_reg >= dbdf_pkg::POS_FIRST_SCORE;
        better    = is_score && (value_in > best_score_reg);
        best_now  = better ? value_in : best_score_reg;
        class_now = better ? (field_position_reg - dbdf_pkg::POS_FIRST_SCORE)
                           : best_class_reg;

        s1_next.last    = s_tlast;
        s1_next.rec_end = rec_end;
        s1_next.best    = best_now;
        s1_next.label   = class_now;
        s1_next.obj     = objectness_reg;
        s1_next.cx      = centre_x_reg;
        s1_next.cy      = centre_y_reg;
        s1_next.sw      = span_w_reg;
        s1_next.sh      = span_h_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_position_reg <= '0;
            centre_x_reg       <= '0;
            centre_y_reg       <= '0;
            span_w_reg         <= '0;
            span_h_reg         <= '0;
            objectness_reg     <= '0;
            best_score_reg     <= dbdf_pkg::VALUE_MIN;
            best_class_reg     <= '0;
        end
        else if (s_accept)
        begin
            case (field_position_reg)
                7'd0:    centre_x_reg   <= value_in;
                7'd1:    centre_y_reg   <= value_in;
                7'd2:    span_w_reg     <= value_in;
                7'd3:    span_h_reg     <= value_in;
                7'd4:    objectness_reg <= value_in;
                default: ;
            endcase
            if (rec_end || s_tlast)
            begin
                field_position_reg <= '0;
                best_score_reg     <= dbdf_pkg::VALUE_MIN;
                best_class_reg     <= '0;
            end
            else
            begin
                field_position_reg <= pos_plus1[dbdf_pkg::POS_W-1:0];
                best_score_reg     <= best_now;
                best_class_reg     <= class_now;
            end
        end
    end

    // Stage 1: snapshot of a record end or a frame close
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_can_load)
            s1_valid_reg <= s_accept && (rec_end || s_tlast);
    end

    always_ff @(posedge clk)
    begin
        if (s1_can_load && s_accept)
            s1_reg <= s1_next;
    end

    // Stage 2: confidence product
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s2_can_load)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_can_load && s1_valid_reg)
        begin
            s2_reg.last    <= s1_reg.last;
            s2_reg.rec_end <= s1_reg.rec_end;
            s2_reg.prod    <= dbdf_pkg::PROD_W'(s1_reg.best) * dbdf_pkg::PROD_W'(s1_reg.obj);
            s2_reg.label   <= s1_reg.label;
            s2_reg.cx      <= s1_reg.cx;
            s2_reg.cy      <= s1_reg.cy;
            s2_reg.sw      <= s1_reg.sw;
            s2_reg.sh      <= s1_reg.sh;
        end
    end

    // Threshold, saturation and corner box
    always_comb
    begin
        conf_full = s2_reg.prod[dbdf_pkg::PROD_W-1:dbdf_pkg::FRAC_W];
        keep      = s2_reg.rec_end &&
                    (conf_full >= $signed({{(dbdf_pkg::CONF_W-dbdf_pkg::THRESH_W){1'b0}},
                                           threshold_reg}));
        emit      = keep || s2_reg.last;

        if (conf_full > $signed({{(dbdf_pkg::CONF_W-VW){1'b0}}, dbdf_pkg::VALUE_MAX}))
            conf_sat = dbdf_pkg::VALUE_MAX;
        else if (conf_full < $signed({{(dbdf_pkg::CONF_W-VW){1'b1}}, dbdf_pkg::VALUE_MIN}))
            conf_sat = dbdf_pkg::VALUE_MIN;
        else
            conf_sat = conf_full[VW-1:0];

        half_w    = s2_reg.sw >>> 1;
        half_h    = s2_reg.sh >>> 1;
        left_full = {s2_reg.cx[VW-1], s2_reg.cx} - {half_w[VW-1], half_w};
        top_full  = {s2_reg.cy[VW-1], s2_reg.cy} - {half_h[VW-1], half_h};

        if (left_full[VW] != left_full[VW-1])
            left_sat = left_full[VW] ? dbdf_pkg::VALUE_MIN : dbdf_pkg::VALUE_MAX;
        else
            left_sat = left_full[VW-1:0];
        if (top_full[VW] != top_full[VW-1])
            top_sat = top_full[VW] ? dbdf_pkg::VALUE_MIN : dbdf_pkg::VALUE_MAX;
        else
            top_sat = top_full[VW-1:0];

        if (keep)
            out_data_next = {1'b0,
                             {s2_reg.sh[VW-1:1], 1'b0},
                             {s2_reg.sw[VW-1:1], 1'b0},
                             top_sat,
                             left_sat,
                             conf_sat,
                             s2_reg.label};
        else
            out_data_next = '0;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_can_load)
            out_valid_reg <= s2_valid_reg && emit;
    end

    always_ff @(posedge clk)
    begin
        if (out_can_load && s2_valid_reg)
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= keep;
            out_last_reg <= s2_reg.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    // A frame close always starts a fresh record
    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept && s_tlast |=> field_position_reg == '0 && best_class_reg == '0
                               && best_score_reg == dbdf_pkg::VALUE_MIN)
        else $error("record state not restarted after frame close");

    // Only frame-close results travel without a kept box, and they carry zeros
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tlast && m_tdata == '0)
        else $error("result without box is not a clean frame close");

    // Spans are reported with their lowest bit cleared
    a_even_span: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> !m_tdata[103] && !m_tdata[135])
        else $error("box span has its lowest bit set");

    // A stalled snapshot holds until the product stage takes it
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s2_can_load |=> s1_valid_reg && $stable(s1_reg))
        else $error("stage 1 lost its transaction under stall");
`endif

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;

    // Run limits
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 200;
    localparam int RANDOM_ITEMS = 430;

    // Result of one closed record or frame, as the block should report it
    typedef struct packed {
        logic                                box_valid;
        logic [dbdf_pkg::LABEL_W-1:0]        label;
        logic signed [dbdf_pkg::VALUE_W-1:0] confidence;
        logic signed [dbdf_pkg::VALUE_W-1:0] left;
        logic signed [dbdf_pkg::VALUE_W-1:0] top;
        logic signed [dbdf_pkg::VALUE_W-1:0] box_width;
        logic signed [dbdf_pkg::VALUE_W-1:0] box_height;
        logic                                frame_done;
    } det_result_t;

    // Receiver ready patterns
    typedef enum logic [1:0] {
        RX_STEADY,
        RX_COIN,
        RX_SPARSE,
        RX_MOSTLY
    } rx_mode_t;

    logic                              clk       = 1'b0;
    logic                              rst_n     = 1'b0;
    logic                              s_tvalid  = 1'b0;
    logic                              s_tready;
    logic [dbdf_pkg::VALUE_W-1:0]      s_tdata   = '0;
    logic                              s_tlast   = 1'b0;
    logic                              m_tvalid;
    logic                              m_tready  = 1'b0;
    logic [dbdf_pkg::OUT_DATA_W-1:0]   m_tdata;
    logic                              m_tuser;
    logic                              m_tlast;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [dbdf_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
    logic [dbdf_pkg::CFG_DATA_W-1:0]   cfg_data  = '0;

    // Decoder state mirror
    logic [dbdf_pkg::LEN_W-1:0]          cur_len    = dbdf_pkg::RECORD_LENGTH_RST;
    logic [dbdf_pkg::THRESH_W-1:0]       cur_thresh = dbdf_pkg::THRESHOLD_RST;
    int                                  rec_pos    = 0;
    logic signed [dbdf_pkg::VALUE_W-1:0] centre_x   = '0;
    logic signed [dbdf_pkg::VALUE_W-1:0] centre_y   = '0;
    logic signed [dbdf_pkg::VALUE_W-1:0] span_w     = '0;
    logic signed [dbdf_pkg::VALUE_W-1:0] span_h     = '0;
    logic signed [dbdf_pkg::VALUE_W-1:0] objectness = '0;
    logic signed [dbdf_pkg::VALUE_W-1:0] best_score = dbdf_pkg::VALUE_MIN;
    int                                  best_class = 0;

    det_result_t expected_boxes[$];

    // Bookkeeping
    int          errors        = 0;
    int          items_sent    = 0;
    int          results_seen  = 0;
    int          boxes_kept    = 0;
    int          frames_closed = 0;
    int          cfg_writes    = 0;
    int          burst_left    = 0;
    bit          sender_gaps   = 1'b1;
    logic [31:0] prev_score    = '0;

    // Receiver control
    int          hold_requests = 0;
    int          hold_served   = 0;
    int          hold_left     = 0;
    int          mode_left     = 0;
    int          sparse_cnt    = 0;
    rx_mode_t    ready_mode    = RX_STEADY;

    always #5 clk = ~clk;

    detection_box_decode_filter_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic int effective_length();
        int n;
        n = cur_len;
        if (n < dbdf_pkg::MIN_RECORD)
            n = dbdf_pkg::MIN_RECORD;
        if (n > dbdf_pkg::MAX_RECORD)
            n = dbdf_pkg::MAX_RECORD;
        return n;
    endfunction

    function automatic logic signed [dbdf_pkg::VALUE_W-1:0] clip32(
        input logic signed [63:0] x);
        if (x > 64'sd2147483647)
            return dbdf_pkg::VALUE_MAX;
        if (x < -64'sd2147483648)
            return dbdf_pkg::VALUE_MIN;
        return x[31:0];
    endfunction

    function automatic void restart_record();
        rec_pos    = 0;
        best_score = dbdf_pkg::VALUE_MIN;
        best_class = 0;
    endfunction

    // Advance the decoder mirror by one value; returns 1 when a result is due
    function automatic bit decode_value(input logic signed [dbdf_pkg::VALUE_W-1:0] v,
                                        input logic last, output det_result_t r);
        int                 span;
        int                 label;
        logic signed [63:0] prod;
        logic signed [63:0] wide;
        logic signed [63:0] conf;
        logic signed [63:0] half_w;
        logic signed [63:0] half_h;
        bit                 keep;
        span = effective_length();
        r    = '0;
        case (rec_pos)
            0: centre_x = v;
            1: centre_y = v;
            2: span_w = v;
            3: span_h = v;
            4: objectness = v;
            default:
            begin
                // strict compare: first maximum keeps the label
                if (v > best_score)
                begin
                    best_score = v;
                    best_class = rec_pos - dbdf_pkg::BOX_FIELDS;
                end
            end
        endcase

        if (rec_pos + 1 >= span)
        begin
            prod  = best_score;
            wide  = objectness;
            prod  = prod * wide;
            conf  = prod >>> dbdf_pkg::FRAC_W;
            keep  = conf >= $signed({47'd0, cur_thresh});
            label = best_class;
            restart_record();
            if (!keep && !last)
                return 1'b0;
            if (keep)
            begin
                half_w       = span_w;
                half_w       = half_w >>> 1;
                half_h       = span_h;
                half_h       = half_h >>> 1;
                r.box_valid  = 1'b1;
                r.label      = label[dbdf_pkg::LABEL_W-1:0];
                r.confidence = clip32(conf);
                wide         = centre_x;
                r.left       = clip32(wide - half_w);
                wide         = centre_y;
                r.top        = clip32(wide - half_h);
                wide         = half_w <<< 1;
                r.box_width  = wide[31:0];
                wide         = half_h <<< 1;
                r.box_height = wide[31:0];
            end
            r.frame_done = last;
            return 1'b1;
        end

        // frame closed before the record ended: partial record dropped
        if (last)
        begin
            restart_record();
            r.frame_done = 1'b1;
            return 1'b1;
        end

        rec_pos++;
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // One input transaction; entered and left at a falling edge
    task automatic push_value(input logic [dbdf_pkg::VALUE_W-1:0] v, input logic last);
        det_result_t r;
        if (sender_gaps)
        begin
            if (burst_left == 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (decode_value(v, last, r))
            expected_boxes = {expected_boxes, r};
        items_sent++;
        @(negedge clk);
    endtask

    task automatic stream_idle();
        s_tvalid <= 1'b0;
        @(negedge clk);
    endtask

    // Wait until every expected result is out, then let the pipeline settle
    task automatic wait_drained();
        while (expected_boxes.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [dbdf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [dbdf_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == dbdf_pkg::REG_RECORD_LENGTH)
            cur_len = val[dbdf_pkg::LEN_W-1:0];
        else if (idx == dbdf_pkg::REG_CONFIDENCE_THRESHOLD)
            cur_thresh = val[dbdf_pkg::THRESH_W-1:0];
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Plausible detector value for record slot k, with some raw noise
    function automatic logic [dbdf_pkg::VALUE_W-1:0] random_field(input int k);
        logic [dbdf_pkg::VALUE_W-1:0] v;
        if ($urandom_range(0, 5) == 0)
            v = $urandom;
        else if (k < 2)
            v = $urandom_range(0, 32'h0280_0000);
        else if (k < 4)
            v = $urandom_range(0, 32'h00C8_0000);
        else if (k == 4)
            v = $urandom_range(0, 32'h0001_0000);
        else if ($urandom_range(0, 7) == 0)
            v = prev_score;
        else
            v = $urandom_range(0, 32'h0001_0000);
        if (k >= dbdf_pkg::BOX_FIELDS)
            prev_score = v;
        return v;
    endfunction

    // One record at the current length; now and then cut short by a frame close
    task automatic send_record(input bit close_frame);
        int n;
        int cut;
        n   = effective_length();
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n - 2) : n;
        for (int k = 0; k < n; k++)
        begin
            if (k == cut)
            begin
                push_value(random_field(k), 1'b1);
                return;
            end
            push_value(random_field(k), close_frame && (k == n - 1));
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: ready pattern of its own, plus long hold-offs on request
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            m_tready    <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                ready_mode <= rx_mode_t'($urandom_range(0, 3));
                mode_left  <= $urandom_range(20, 80);
            end
            else
                mode_left <= mode_left - 1;
            sparse_cnt <= sparse_cnt + 1;
            case (ready_mode)
                RX_STEADY: m_tready <= 1'b1;
                RX_COIN:   m_tready <= $urandom_range(0, 1);
                RX_SPARSE: m_tready <= (sparse_cnt % 4) == 0;
                default:   m_tready <= $urandom_range(0, 4) != 0;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t ns: %s expected %h actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        det_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (m_tuser === 1'b1)
                boxes_kept++;
            if (m_tlast === 1'b1)
                frames_closed++;
            if (expected_boxes.size() == 0)
            begin
                errors++;
                $display("%0t ns: result transaction with nothing expected, tdata %h",
                         $time, m_tdata);
            end
            else
            begin
                want = expected_boxes.pop_front();
                compare_field("box_valid", want.box_valid, m_tuser);
                compare_field("label", want.label, m_tdata[6:0]);
                compare_field("confidence", want.confidence, m_tdata[38:7]);
                compare_field("left", want.left, m_tdata[70:39]);
                compare_field("top", want.top, m_tdata[102:71]);
                compare_field("box_width", want.box_width, m_tdata[134:103]);
                compare_field("box_height", want.box_height, m_tdata[166:135]);
                compare_field("frame_done", want.frame_done, m_tlast);
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Writes to unknown indexes must leave both registers alone
    task automatic test_ignored_index();
        write_reg(8'd2, 17'h1FFFF);
        write_reg(8'hFF, 17'h00000);
        write_reg(dbdf_pkg::CFG_IDX_W'($urandom_range(3, 254)),
                  dbdf_pkg::CFG_DATA_W'($urandom));
    endtask

    // Equal top scores: the first one gives the label; reset threshold
    task automatic test_tie_first_max();
        write_reg(dbdf_pkg::REG_RECORD_LENGTH, 17'd7);
        push_value(32'h0010_0000, 1'b0);
        push_value(32'h0020_0000, 1'b0);
        push_value(32'h0008_0001, 1'b0);
        push_value(32'h0004_0003, 1'b0);
        push_value(32'h0001_0000, 1'b0);
        push_value(32'h0000_C000, 1'b0);
        push_value(32'h0000_C000, 1'b0);
    endtask

    // Length 0 acts as the minimum; confidence one below reset threshold drops the box
    task automatic test_short_length_below_threshold();
        stream_idle();
        wait_drained();
        write_reg(dbdf_pkg::REG_RECORD_LENGTH, 17'd0);
        push_value(32'h0001_0000, 1'b0);
        push_value(32'h0002_0000, 1'b0);
        push_value(32'h0003_0000, 1'b0);
        push_value(32'h0004_0000, 1'b0);
        push_value(32'h0001_0000, 1'b0);
        push_value(32'd22937, 1'b0);
    endtask

    // Extreme values: saturated corners and confidence, top threshold, frame close
    task automatic test_extremes();
        stream_idle();
        wait_drained();
        write_reg(dbdf_pkg::REG_CONFIDENCE_THRESHOLD, 17'h1FFFF);
        push_value(dbdf_pkg::VALUE_MAX, 1'b0);
        push_value(dbdf_pkg::VALUE_MIN, 1'b0);
        push_value(dbdf_pkg::VALUE_MIN, 1'b0);
        push_value(dbdf_pkg::VALUE_MAX, 1'b0);
        push_value(dbdf_pkg::VALUE_MIN, 1'b0);
        push_value(dbdf_pkg::VALUE_MIN, 1'b1);
    endtask

    // Frame closed in the middle of a record
    task automatic test_mid_record_close();
        push_value(32'hDEAD_BEEF, 1'b0);
        push_value(32'h1234_5678, 1'b1);
    endtask

    // Shrinking the length below the current position ends the record at once
    task automatic test_shrink_mid_record();
        stream_idle();
        wait_drained();
        write_reg(dbdf_pkg::REG_RECORD_LENGTH, 17'd20);
        push_value(32'h0040_0000, 1'b0);
        push_value(32'h0030_0000, 1'b0);
        push_value(32'h0010_0000, 1'b0);
        push_value(32'h0008_0000, 1'b0);
        push_value(32'h0002_0000, 1'b0);
        push_value(32'h0001_8000, 1'b0);
        stream_idle();
        wait_drained();
        write_reg(dbdf_pkg::REG_RECORD_LENGTH, 17'd6);
        push_value(32'h0001_8000, 1'b0);
    endtask

    // Receiver holds off for a long stretch while every input closes a frame
    task automatic test_output_stall();
        stream_idle();
        wait_drained();
        write_reg(dbdf_pkg::REG_CONFIDENCE_THRESHOLD, 17'd0);
        sender_gaps = 1'b0;
        hold_requests++;
        repeat (40) push_value($urandom, 1'b1);
        sender_gaps = 1'b1;
        stream_idle();
        wait_drained();
    endtask

    // Phases of random records under changing register settings
    task automatic test_random_traffic();
        int   goal;
        int   recs;
        int   pick;
        logic [dbdf_pkg::LEN_W-1:0]    len;
        logic [dbdf_pkg::THRESH_W-1:0] thr;
        goal = items_sent + RANDOM_ITEMS;
        while (items_sent < goal)
        begin
            pick = $urandom_range(0, 39);
            case (pick)
                0:       len = 8'd0;
                1:       len = 8'd255;
                2:       len = 8'd128;
                3:       len = 8'd5;
                4:       len = 8'd6;
                default: len = $urandom_range(6, 16);
            endcase
            pick = $urandom_range(0, 9);
            case (pick)
                0:       thr = 17'd0;
                1:       thr = 17'h1FFFF;
                2:       thr = 17'h10000;
                3:       thr = $urandom_range(0, 131071);
                default: thr = $urandom_range(0, 49152);
            endcase
            // upper data bits are ignored by the length register
            if ($urandom_range(0, 1))
            begin
                write_reg(dbdf_pkg::REG_RECORD_LENGTH, {9'($urandom), len});
                write_reg(dbdf_pkg::REG_CONFIDENCE_THRESHOLD, thr);
            end
            else
            begin
                write_reg(dbdf_pkg::REG_CONFIDENCE_THRESHOLD, thr);
                write_reg(dbdf_pkg::REG_RECORD_LENGTH, {9'($urandom), len});
            end
            sender_gaps = $urandom_range(0, 3) != 0;
            recs = 60 / effective_length();
            if (recs < 1)
                recs = 1;
            repeat (recs) send_record($urandom_range(0, 3) == 0);
            stream_idle();
            wait_drained();
        end
        sender_gaps = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_ignored_index();
        test_tie_first_max();
        test_short_length_below_threshold();
        test_extremes();
        test_mid_record_close();
        test_shrink_mid_record();
        test_output_stall();
        test_random_traffic();

        stream_idle();
        wait_drained();
        repeat (10) @(negedge clk);

        $display("Sent %0d values through %0d register writes; checked %0d results",
                 items_sent, cfg_writes, results_seen);
        $display("of which %0d kept boxes and %0d frame closes", boxes_kept, frames_closed);
        if (errors == 0 && expected_boxes.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("Timeout with %0d results still expected", expected_boxes.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* filelist.f */
rtl/dbdf_pkg.sv
rtl/detection_box_decode_filter_core.sv
tb/tb.sv
